>>> src/disk_block_bitmap_allocator_top_defines.svh
// assertion macros used by the allocator sequencer
`ifndef DISK_BLOCK_BITMAP_ALLOCATOR_TOP_DEFINES_SVH
`define DISK_BLOCK_BITMAP_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define DBBA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");

// next-cycle implication, off during reset
`define DBBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

>>> src/dbba_pkg.sv
// shared types, codes and defaults for the block bitmap allocator
`default_nettype none

package dbba_pkg;

   // default sizing
   localparam int NUM_BLOCKS_DEF = 128;
   localparam int MAX_RUN_DEF    = 32;

   // field widths
   localparam int FUNC_W   = 2;
   localparam int START_W  = 7;
   localparam int LEN_W    = 6;
   localparam int BLOCK_W  = 7;
   localparam int STATUS_W = 2;

   // operation codes
   localparam logic [FUNC_W-1:0] FN_CONTIG  = 2'd0;
   localparam logic [FUNC_W-1:0] FN_SCATTER = 2'd1;
   localparam logic [FUNC_W-1:0] FN_MARK    = 2'd2;
   localparam logic [FUNC_W-1:0] FN_NONE    = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_USED  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SPACE = 2'd3;

   // one result item from the sequencer to the output stage
   typedef struct packed {
      logic [BLOCK_W-1:0]  block;
      logic [STATUS_W-1:0] status;
      logic                last;
   } rsp_item_type;

endpackage

`default_nettype wire

>>> src/dbba_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module dbba_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 128,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/dbba_out.sv
// result output register for the allocator
`default_nettype none

module dbba_out import dbba_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                issue,
   input  wire rsp_item_type        item,
   output logic                     slot_free,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic      [BLOCK_W-1:0]  rsp_block,
   output logic      [STATUS_W-1:0] rsp_status,
   output logic                     rsp_last
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   // slot opens when empty or when the held item leaves this cycle
   assign slot_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (issue) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (issue) begin
         item_ff <= item;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_block  = item_ff.block;
   assign rsp_status = item_ff.status;
   assign rsp_last   = item_ff.last;

endmodule

`default_nettype wire

>>> src/dbba_seq.sv
// request sequencer: decodes, scans the map one block a cycle unless a stalled result holds it, and emits results
`default_nettype none

`include "disk_block_bitmap_allocator_top_defines.svh"

module dbba_seq import dbba_pkg::*; #(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
   parameter int MAX_RUN    = MAX_RUN_DEF,
   localparam int AW        = $clog2(NUM_BLOCKS)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic [FUNC_W-1:0]  req_func,
   input  wire logic [START_W-1:0] req_start_req,
   input  wire logic [LEN_W-1:0]   req_length,
   output logic                    idle,
   input  wire logic               out_free,
   output logic                    issue,
   output rsp_item_type            item,
   output logic                    wr_en,
   output logic      [AW-1:0]      wr_addr,
   output logic                    wr_data,
   output logic                    rd_en,
   output logic      [AW-1:0]      rd_addr,
   input  wire logic               rd_data
);

   // block counters hold the disk size and start plus length
   localparam int CW = (AW + 1 > 8) ? AW + 1 : 8;
   localparam logic [CW-1:0] NB_C = CW'(NUM_BLOCKS);

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_DECODE  = 3'd2;
   localparam logic [2:0] S_SCAN    = 3'd3;
   localparam logic [2:0] S_FILL    = 3'd4;
   localparam logic [2:0] S_WALK    = 3'd5;
   localparam logic [2:0] S_MARK_EV = 3'd6;
   localparam logic [2:0] S_ONE     = 3'd7;

   logic [2:0]          state_ff,      state_in;
   logic                pend_ff,       pend_in;
   logic [CW-1:0]       rd_addr_ff,    rd_addr_in;
   logic [CW-1:0]       ev_addr_ff,    ev_addr_in;
   logic [CW-1:0]       start_ff,      start_in;
   logic [CW-1:0]       end_ff,        end_in;
   logic [FUNC_W-1:0]   func_ff,       func_in;
   logic [LEN_W-1:0]    len_ff,        len_in;
   logic [LEN_W-1:0]    cnt_ff,        cnt_in;
   logic [CW-1:0]       res_block_ff,  res_block_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;

   logic walk_take;
   logic walk_last;
   logic fill_last;
   logic len_bad;

   assign idle      = (state_ff == S_IDLE);
   assign walk_take = pend_ff && !rd_data;
   assign walk_last = ((cnt_ff + LEN_W'(1)) == len_ff);
   assign fill_last = ((rd_addr_ff + CW'(1)) == end_ff);
   assign len_bad   = (len_ff == '0) || ({1'b0, len_ff} > (LEN_W + 1)'(MAX_RUN));

   // next-state and datapath control
   always_comb begin
      state_in      = state_ff;
      pend_in       = pend_ff;
      rd_addr_in    = rd_addr_ff;
      ev_addr_in    = ev_addr_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      func_in       = func_ff;
      len_in        = len_ff;
      cnt_in        = cnt_ff;
      res_block_in  = res_block_ff;
      res_status_in = res_status_ff;
      issue         = 1'b0;
      item          = '0;
      wr_en         = 1'b0;
      wr_addr       = rd_addr_ff[AW-1:0];
      wr_data       = 1'b1;
      rd_en         = 1'b0;
      rd_addr       = rd_addr_ff[AW-1:0];

      unique case (state_ff)
         // clearing pass over the map after reset
         S_CLEAR: begin
            wr_en      = 1'b1;
            wr_data    = 1'b0;
            rd_addr_in = rd_addr_ff + CW'(1);
            if (rd_addr_ff == NB_C - CW'(1)) begin
               state_in = S_IDLE;
            end
         end

         // take a new item
         S_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               start_in = CW'(req_start_req);
               len_in   = req_length;
               state_in = S_DECODE;
            end
         end

         // range checks and dispatch
         S_DECODE: begin
            end_in        = start_ff + CW'(len_ff);
            rd_addr_in    = start_ff;
            pend_in       = 1'b0;
            cnt_in        = '0;
            res_block_in  = start_ff;
            res_status_in = ST_RANGE;
            priority if (func_ff == FN_NONE) begin
               state_in = S_IDLE;
            end else if (start_ff >= NB_C) begin
               state_in = S_ONE;
            end else if (func_ff == FN_MARK) begin
               rd_en    = 1'b1;
               rd_addr  = start_ff[AW-1:0];
               state_in = S_MARK_EV;
            end else if (len_bad) begin
               state_in = S_ONE;
            end else if (func_ff == FN_CONTIG && (start_ff + CW'(len_ff)) > NB_C) begin
               state_in = S_ONE;
            end else if (func_ff == FN_CONTIG) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_WALK;
            end
         end

         // single block mark
         S_MARK_EV: begin
            if (out_free) begin
               issue      = 1'b1;
               item.block = start_ff[BLOCK_W-1:0];
               item.last  = 1'b1;
               if (rd_data) begin
                  item.status = ST_USED;
               end else begin
                  wr_en       = 1'b1;
                  wr_addr     = start_ff[AW-1:0];
                  item.status = ST_OK;
               end
               state_in = S_IDLE;
            end
         end

         // contiguous run: check every block before marking any
         S_SCAN: begin
            if (pend_ff && rd_data) begin
               res_block_in  = ev_addr_ff;
               res_status_in = ST_USED;
               pend_in       = 1'b0;
               state_in      = S_ONE;
            end else if (rd_addr_ff != end_ff) begin
               rd_en      = 1'b1;
               rd_addr_in = rd_addr_ff + CW'(1);
               ev_addr_in = rd_addr_ff;
               pend_in    = 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               rd_addr_in = start_ff;
               state_in   = S_FILL;
            end
         end

         // contiguous run: mark and report one block a cycle while the result slot is free
         S_FILL: begin
            if (out_free) begin
               wr_en       = 1'b1;
               issue       = 1'b1;
               item.block  = rd_addr_ff[BLOCK_W-1:0];
               item.status = ST_OK;
               item.last   = fill_last;
               rd_addr_in  = rd_addr_ff + CW'(1);
               if (fill_last) begin
                  state_in = S_IDLE;
               end
            end
         end

         // scattered run: read ahead while the previous block is taken or skipped
         S_WALK: begin
            if (!walk_take || out_free) begin
               if (walk_take) begin
                  wr_en       = 1'b1;
                  wr_addr     = ev_addr_ff[AW-1:0];
                  issue       = 1'b1;
                  item.block  = ev_addr_ff[BLOCK_W-1:0];
                  item.status = ST_OK;
                  item.last   = walk_last;
                  cnt_in      = cnt_ff + LEN_W'(1);
               end
               priority if (walk_take && walk_last) begin
                  pend_in  = 1'b0;
                  state_in = S_IDLE;
               end else if (rd_addr_ff < NB_C) begin
                  rd_en      = 1'b1;
                  rd_addr_in = rd_addr_ff + CW'(1);
                  ev_addr_in = rd_addr_ff;
                  pend_in    = 1'b1;
               end else if (pend_ff) begin
                  pend_in = 1'b0;
               end else begin
                  res_block_in  = '0;
                  res_status_in = ST_SPACE;
                  state_in      = S_ONE;
               end
            end
         end

         // single closing result: range error, used block or out of space
         S_ONE: begin
            if (out_free) begin
               issue       = 1'b1;
               item.block  = res_block_ff[BLOCK_W-1:0];
               item.status = res_status_ff;
               item.last   = 1'b1;
               state_in    = S_IDLE;
            end
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         pend_ff    <= 1'b0;
         rd_addr_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pend_ff    <= pend_in;
         rd_addr_ff <= rd_addr_in;
      end
   end

   // item and scan payload
   always_ff @(posedge clock) begin
      ev_addr_ff    <= ev_addr_in;
      start_ff      <= start_in;
      end_ff        <= end_in;
      func_ff       <= func_in;
      len_ff        <= len_in;
      cnt_ff        <= cnt_in;
      res_block_ff  <= res_block_in;
      res_status_ff <= res_status_in;
   end

   `DBBA_ASSERT_IMP(a_issue_slot_free, clock, reset, issue, out_free)
   `DBBA_ASSERT_IMP(a_wr_rd_apart, clock, reset, wr_en && rd_en, wr_addr != rd_addr)
   `DBBA_ASSERT_NEXT(a_accept_decode, clock, reset, idle && req_valid, state_ff == S_DECODE)
   `DBBA_ASSERT_IMP(a_pend_in_scan, clock, reset, pend_ff, state_ff == S_SCAN || state_ff == S_WALK)

endmodule

`default_nettype wire

>>> src/disk_block_bitmap_allocator_top.sv
// free block bitmap allocator top level
//
//   channel | ports                              | direction
//   --------+------------------------------------+----------
//   request | req_valid req_stall req_func        | in
//           | req_start_req req_length            |
//   result  | rsp_valid rsp_stall rsp_block       | out
//           | rsp_status rsp_last                 |
//
// one item at a time; the map is read and written one block per cycle while no stalled
// result holds it, through a single ram port pair, which sets the item time
// after reset a clearing pass marks every block free before the first item
// req_stall is high while the sequencer is not idle, during that pass as well
// a stalled result holds the sequencer
`default_nettype none

module disk_block_bitmap_allocator_top import dbba_pkg::*; #(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
   parameter int MAX_RUN    = MAX_RUN_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [FUNC_W-1:0]   req_func,
   input  wire logic [START_W-1:0]  req_start_req,
   input  wire logic [LEN_W-1:0]    req_length,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic      [BLOCK_W-1:0]  rsp_block,
   output logic      [STATUS_W-1:0] rsp_status,
   output logic                     rsp_last
);

   localparam int AW = $clog2(NUM_BLOCKS);

   logic         seq_idle;
   logic         out_free;
   logic         issue;
   rsp_item_type item;
   logic         wr_en;
   logic [AW-1:0] wr_addr;
   logic         wr_data;
   logic         rd_en;
   logic [AW-1:0] rd_addr;
   logic [0:0]   rd_data;

   assign req_stall = !seq_idle;

   // allocation map, one bit per block
   dbba_ram #(
      .WIDTH (1),
      .DEPTH (NUM_BLOCKS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer
   dbba_seq #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .MAX_RUN    (MAX_RUN)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_func      (req_func),
      .req_start_req (req_start_req),
      .req_length    (req_length),
      .idle          (seq_idle),
      .out_free      (out_free),
      .issue         (issue),
      .item          (item),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data[0])
   );

   // result register
   dbba_out u_out (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .item       (item),
      .slot_free  (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_block  (rsp_block),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

endmodule

`default_nettype wire
